### sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

   // Capacity of the queue and derived widths
   localparam int DEPTH   = 16;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VAL_W   = 16;
   localparam int PRI_W   = 8;
   localparam int OCC_W   = 5;
   localparam int STAT_W  = 2;
   localparam int CMD_W   = 2;
   localparam int ENTRY_W = VAL_W + PRI_W;

   // Stream packing widths
   localparam int REQ_DATA_W = ((VAL_W + PRI_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((VAL_W + PRI_W + OCC_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // One slot of the queue memory
   typedef struct packed {
      logic [PRI_W-1:0]        prio;
      logic signed [VAL_W-1:0] value;
   } entry_type;

   // One accepted request
   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic signed [VAL_W-1:0] value;
      logic [PRI_W-1:0]        prio;
   } req_type;

   // One result item
   typedef struct packed {
      status_type              status;
      logic signed [VAL_W-1:0] value;
      logic [PRI_W-1:0]        prio;
      logic [OCC_W-1:0]        occupancy;
      logic                    last;
   } result_type;

   // Slot memory access from the controller
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

### sv/spq_ram.sv
// Generic simple dual-port RAM with registered read.
module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/spq_out.sv
// Result output register that decouples the controller from the result stream.
module spq_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_valid,
   input  spq_pkg::result_type res,
   output logic                out_free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output spq_pkg::result_type rsp
);
   import spq_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // Free when empty or being drained this cycle
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (res_valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   // Hold the result until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

### sv/spq_ctrl.sv
// Sequencer that scans, shifts and reads out the slot memory.
module spq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  spq_pkg::req_type     req,
   output spq_pkg::mem_req_type mem,
   input  spq_pkg::entry_type   rd_data,
   input  logic                 out_free,
   output logic                 res_valid,
   output spq_pkg::result_type  res
);
   import spq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS,
      S_INS_HEAD,
      S_DEL_FIND,
      S_DEL_SHIFT,
      S_READ,
      S_RESP
   } state_type;

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic [PRI_W-1:0]        pri_ff, pri_in;
   status_type              status_ff, status_in;

   logic [ADDR_W-1:0]        last_idx;
   logic [ADDR_W-1:0]        idx_next;
   logic [ADDR_W-1:0]        idx_prev;
   logic [CNT_W+OCC_W-1:0]   occ_wide;
   logic [OCC_W-1:0]         occ;
   entry_type                new_entry;

   assign last_idx  = ADDR_W'(count_ff - CNT_W'(1));
   assign idx_next  = idx_ff + ADDR_W'(1);
   assign idx_prev  = idx_ff - ADDR_W'(1);
   assign occ_wide  = {{OCC_W{1'b0}}, count_ff};
   assign occ       = occ_wide[OCC_W-1:0];
   assign new_entry = '{prio: pri_ff, value: val_ff};

   // Next state, memory accesses and result
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      val_in    = val_ff;
      pri_in    = pri_ff;
      status_in = status_ff;
      req_ready = 1'b0;
      mem       = '0;
      res_valid = 1'b0;
      res       = '{status: ST_OK, value: '0, prio: '0, occupancy: occ, last: 1'b1};

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               val_in    = req.value;
               pri_in    = req.prio;
               status_in = ST_OK;
               state_in  = S_RESP;
               case (req.command)
                  CMD_INSERT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else if (count_ff == '0) begin
                        mem.wr_en   = 1'b1;
                        mem.wr_addr = '0;
                        mem.wr_data = '{prio: req.prio, value: req.value};
                        count_in    = count_ff + CNT_W'(1);
                     end else begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = last_idx;
                        idx_in      = last_idx;
                        state_in    = S_INS;
                     end
                  end
                  CMD_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = '0;
                        idx_in      = '0;
                        state_in    = S_DEL_FIND;
                     end
                  end
                  CMD_READ: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = '0;
                        idx_in      = '0;
                        state_in    = S_READ;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end

         // Walk from the tail, moving larger priorities up one slot
         S_INS: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = idx_next;
            if (rd_data.prio <= pri_ff) begin
               mem.wr_data = new_entry;
               count_in    = count_ff + CNT_W'(1);
               status_in   = ST_OK;
               state_in    = S_RESP;
            end else begin
               mem.wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = S_INS_HEAD;
               end else begin
                  mem.rd_en   = 1'b1;
                  mem.rd_addr = idx_prev;
                  idx_in      = idx_prev;
               end
            end
         end

         // New entry goes to the head
         S_INS_HEAD: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = '0;
            mem.wr_data = new_entry;
            count_in    = count_ff + CNT_W'(1);
            status_in   = ST_OK;
            state_in    = S_RESP;
         end

         // Search from the head for the value
         S_DEL_FIND: begin
            if (rd_data.value == val_ff) begin
               if (idx_ff == last_idx) begin
                  count_in  = count_ff - CNT_W'(1);
                  status_in = ST_OK;
                  state_in  = S_RESP;
               end else begin
                  mem.rd_en   = 1'b1;
                  mem.rd_addr = idx_next;
                  state_in    = S_DEL_SHIFT;
               end
            end else if (idx_ff == last_idx) begin
               status_in = ST_NOTFOUND;
               state_in  = S_RESP;
            end else begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = idx_next;
               idx_in      = idx_next;
            end
         end

         // Close the gap: move each later entry down one slot
         S_DEL_SHIFT: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = idx_ff;
            mem.wr_data = rd_data;
            if (idx_next == last_idx) begin
               count_in  = count_ff - CNT_W'(1);
               status_in = ST_OK;
               state_in  = S_RESP;
            end else begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = idx_next + ADDR_W'(1);
               idx_in      = idx_next;
            end
         end

         // Emit one entry per transfer, head to tail
         S_READ: begin
            if (out_free) begin
               res_valid = 1'b1;
               res = '{status: ST_OK, value: rd_data.value, prio: rd_data.prio,
                       occupancy: occ, last: (idx_ff == last_idx)};
               if (idx_ff == last_idx) begin
                  state_in = S_IDLE;
               end else begin
                  mem.rd_en   = 1'b1;
                  mem.rd_addr = idx_next;
                  idx_in      = idx_next;
               end
            end
         end

         // Single status result
         S_RESP: begin
            if (out_free) begin
               res_valid = 1'b1;
               res.status = status_ff;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      pri_ff    <= pri_in;
      status_ff <= status_in;
   end

   // Occupancy never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   // A result is only produced when the output stage can take it
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("result produced while output stage busy");

   // Count moves by at most one per request
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CNT_W'(1) ||
          count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("entry count jumped");

   // Shifting never reads the slot being written
   assert property (@(posedge clock) disable iff (reset)
      (mem.wr_en && mem.rd_en) |-> (mem.wr_addr != mem.rd_addr))
      else $error("read and write of the same slot in one cycle");

   // New requests are only taken while idle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted request did not start");

endmodule

### sv/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: stream ports, slot memory, sequencer, output stage.
//
// Bounded priority queue held in ascending priority order in one slot memory
// with a registered read. One request is worked on at a time. An insert scans
// from the tail and moves one entry per cycle; an insert into an empty queue
// writes the head slot directly. A delete scans from the head and shifts the
// rest down, one slot per cycle. A read-out delivers one entry per cycle while
// the result side takes them. Rejected and empty cases answer with a single
// status result. The memory's single read port paces the scans. No clearing
// pass follows reset; the queue is empty at once.
module sorted_priority_queue_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [15:0] item_value, [23:16] item_priority
   input  logic [spq_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [spq_pkg::CMD_W-1:0]      req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [15:0] entry_value, [23:16] entry_priority, [28:24] occupancy, rest zero
   output logic [spq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [spq_pkg::STAT_W-1:0]     rsp_tuser,
   output logic                           rsp_tlast
);
   import spq_pkg::*;

   req_type     req;
   mem_req_type mem;
   entry_type   rd_data;
   logic        out_free;
   logic        res_valid;
   result_type  res;
   result_type  rsp;

   // Unpack the request transfer
   assign req.command = req_tuser;
   assign req.value   = req_tdata[VAL_W-1:0];
   assign req.prio    = req_tdata[VAL_W+PRI_W-1:VAL_W];

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .mem       (mem),
      .rd_data   (rd_data),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res)
   );

   spq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (rd_data)
   );

   spq_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // Pack the result transfer
   assign rsp_tdata = {{(RSP_DATA_W - VAL_W - PRI_W - OCC_W){1'b0}},
                       rsp.occupancy, rsp.prio, rsp.value};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

endmodule
